FILE: hw/rtl/usbtd_pkg.sv
// ----------------------------------------------------------------------------
// usbtd_pkg
// Shared types, constants and word builders for the TD chain builder.
// ----------------------------------------------------------------------------
package usbtd_pkg;

   localparam int MAX_DESCRIPTORS   = 40;
   localparam int BULK_PACKET_BYTES = 64;
   localparam int CNT_W             = $clog2(MAX_DESCRIPTORS + 1);
   localparam int PKT_W             = 11;
   localparam int TOTAL_W           = 17;

   localparam logic [PKT_W-1:0]   BULK_PKT     = PKT_W'(BULK_PACKET_BYTES);
   localparam logic [PKT_W-1:0]   DEFAULT_MP0  = PKT_W'(8);
   localparam logic [PKT_W-1:0]   SETUP_BYTES  = PKT_W'(8);
   localparam logic [10:0]        LEN_MASK     = 11'h7FF;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX    = 17'h1FFFF;

   localparam logic [7:0]  PID_SETUP  = 8'h2D;
   localparam logic [7:0]  PID_IN     = 8'h69;
   localparam logic [7:0]  PID_OUT    = 8'hE1;
   localparam logic [31:0] CS_ACTIVE  = 32'h1 << 25;
   localparam logic [31:0] CS_LS      = 32'h1 << 28;
   localparam logic [31:0] CS_SPD     = 32'h1 << 31;
   localparam logic [31:0] CS_ERRCNT  = 32'h3 << 29;
   localparam logic [31:0] CS_ERRBITS = 32'h01F80000;

   typedef enum logic [1:0] {
      OP_CONTROL = 2'd0,
      OP_BULK    = 2'd1,
      OP_CHECK   = 2'd2,
      OP_UNUSED  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DATA,
      ST_STATUS,
      ST_BULK,
      ST_CHECK
   } state_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_SETUP,
      EMIT_DATA,
      EMIT_STATUS,
      EMIT_BULK,
      EMIT_ERROR,
      EMIT_CHECK
   } emit_type;

   typedef struct packed {
      logic     load;
      emit_type emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic rem_zero;
      logic data_done;
      logic bulk_last;
   } stat_type;

   function automatic logic [31:0] make_token(input logic [10:0] maxlen,
                                              input logic        toggle,
                                              input logic [3:0]  ep,
                                              input logic [6:0]  addr,
                                              input logic [7:0]  pid);
      make_token = {maxlen, 1'b0, toggle, ep, addr, pid};
   endfunction

   function automatic logic [31:0] make_control(input logic ls,
                                                input logic [7:0] pid);
      logic [31:0] cs;
      cs = CS_ACTIVE | CS_ERRCNT;
      if (ls) cs = cs | CS_LS;
      if (pid == PID_IN) cs = cs | CS_SPD;
      make_control = cs;
   endfunction

endpackage

FILE: hw/rtl/usbtd_ctrl.sv
// ----------------------------------------------------------------------------
// usbtd_ctrl
// Sequencer: takes requests and steps the datapath through a descriptor chain.
// ----------------------------------------------------------------------------
module usbtd_ctrl
   import usbtd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  stat_type   stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (opcode_type'(req_opcode))
                  OP_CONTROL: state_in = ST_SETUP;
                  OP_BULK:    state_in = ST_BULK;
                  OP_CHECK:   state_in = ST_CHECK;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SETUP: begin
            if (stat.out_free) state_in = ST_DATA;
         end
         ST_DATA: begin
            if (stat.data_done) state_in = ST_STATUS;
         end
         ST_STATUS: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         ST_BULK: begin
            if (stat.out_free && (stat.rem_zero || stat.bulk_last)) state_in = ST_IDLE;
         end
         ST_CHECK: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.emit  = EMIT_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SETUP: begin
            if (stat.out_free) cmd.emit = EMIT_SETUP;
         end
         ST_DATA: begin
            if (!stat.data_done && stat.out_free) cmd.emit = EMIT_DATA;
         end
         ST_STATUS: begin
            if (stat.out_free) cmd.emit = EMIT_STATUS;
         end
         ST_BULK: begin
            if (stat.out_free) cmd.emit = stat.rem_zero ? EMIT_ERROR : EMIT_BULK;
         end
         ST_CHECK: begin
            if (stat.out_free) cmd.emit = EMIT_CHECK;
         end
         default: begin
            cmd.emit = EMIT_NONE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/usbtd_dp.sv
// ----------------------------------------------------------------------------
// usbtd_dp
// Request registers, packet splitter, toggles, check accumulator, result register.
// ----------------------------------------------------------------------------
module usbtd_dp
   import usbtd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [1:0]  req_opcode,
   input  logic [6:0]  req_dev_address,
   input  logic [3:0]  req_endpoint,
   input  logic        req_ls_dev,
   input  logic        req_dir_in,
   input  logic [15:0] req_transfer_length,
   input  logic [7:0]  req_mp0_bytes,
   input  logic [31:0] req_buffer_address,
   input  logic [31:0] req_setup_address,
   input  logic [31:0] req_td_status,
   input  logic        req_td_was_in,
   input  logic        req_td_final,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_td_control,
   output logic [31:0] rsp_td_token,
   output logic [31:0] rsp_td_buffer,
   output logic        rsp_last,
   output logic        rsp_request_error,
   output logic        rsp_transfer_ok,
   output logic        rsp_timed_out,
   output logic [16:0] rsp_actual_total
);

   // request registers
   logic [6:0]       addr_ff;
   logic [3:0]       ep_ff;
   logic             ls_ff, din_ff, len_nz_ff;
   logic [15:0]      rem_ff, rem_in;
   logic [PKT_W-1:0] pkt_ff;
   logic [31:0]      buf_ff, buf_in, sbuf_ff;
   logic [31:0]      st_ff;
   logic             was_in_ff, fin_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             tog_ff, tog_in;

   // persistent state
   logic               tog_bin_ff, tog_bin_in, tog_bout_ff, tog_bout_in;
   logic               ok_ff, ok_in, stop_ff, stop_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   // result register
   logic               vld_ff, vld_in;
   logic [31:0]        ctl_ff, ctl_in, tok_ff, tok_in, obuf_ff, obuf_in;
   logic               last_ff, last_in, err_ff, err_in;
   logic               rok_ff, rok_in, rto_ff, rto_in;
   logic [TOTAL_W-1:0] rtot_ff, rtot_in;

   logic [15:0]  chunk;
   logic [10:0]  maxlen;
   logic [7:0]   dpid, spid;
   logic         btog;
   logic [10:0]  got;
   logic [TOTAL_W:0] sum;
   logic         c_ok, c_stop;
   logic [TOTAL_W-1:0] c_total;
   logic         emitting;

   assign chunk  = (rem_ff > 16'(pkt_ff)) ? 16'(pkt_ff) : rem_ff;
   assign maxlen = 11'(chunk - 16'd1);
   assign dpid   = din_ff ? PID_IN : PID_OUT;
   assign spid   = (len_nz_ff && din_ff) ? PID_OUT : PID_IN;
   assign btog   = din_ff ? tog_bin_ff : tog_bout_ff;

   assign stat.out_free  = !vld_ff || rsp_ready;
   assign stat.rem_zero  = (rem_ff == 16'd0);
   assign stat.data_done = (rem_ff == 16'd0) || (cnt_ff >= CNT_W'(MAX_DESCRIPTORS - 2));
   assign stat.bulk_last = (rem_ff == chunk) || (cnt_ff == CNT_W'(MAX_DESCRIPTORS - 1));
   assign emitting       = (cmd.emit != EMIT_NONE);

   // check fold, an active word stops counting until the chain ends
   always_comb begin
      got     = (st_ff[10:0] + 11'd1) & LEN_MASK;
      sum     = {1'b0, total_ff} + (TOTAL_W + 1)'(got);
      c_ok    = ok_ff;
      c_stop  = stop_ff;
      c_total = total_ff;
      if (!stop_ff) begin
         if ((st_ff & CS_ACTIVE) != 32'd0) begin
            c_ok   = 1'b0;
            c_stop = 1'b1;
         end else begin
            if ((st_ff & CS_ERRBITS) != 32'd0) c_ok = 1'b0;
            if (was_in_ff) c_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
         end
      end
   end

   always_comb begin
      rem_in      = rem_ff;
      buf_in      = buf_ff;
      cnt_in      = cnt_ff;
      tog_in      = tog_ff;
      tog_bin_in  = tog_bin_ff;
      tog_bout_in = tog_bout_ff;
      ok_in       = ok_ff;
      stop_in     = stop_ff;
      total_in    = total_ff;
      vld_in      = vld_ff && !rsp_ready;
      ctl_in      = ctl_ff;
      tok_in      = tok_ff;
      obuf_in     = obuf_ff;
      last_in     = last_ff;
      err_in      = err_ff;
      rok_in      = rok_ff;
      rto_in      = rto_ff;
      rtot_in     = rtot_ff;

      if (cmd.load) begin
         rem_in = req_transfer_length;
         buf_in = req_buffer_address;
         cnt_in = '0;
         tog_in = 1'b1;
         if (req_opcode == OP_CONTROL || req_opcode == OP_BULK) begin
            ok_in    = 1'b1;
            stop_in  = 1'b0;
            total_in = '0;
         end
      end

      if (emitting) begin
         vld_in  = 1'b1;
         ctl_in  = 32'd0;
         tok_in  = 32'd0;
         obuf_in = 32'd0;
         last_in = 1'b0;
         err_in  = 1'b0;
         rok_in  = 1'b0;
         rto_in  = 1'b0;
         rtot_in = '0;
         cnt_in  = cnt_ff + CNT_W'(1);
      end

      case (cmd.emit)
         EMIT_SETUP: begin
            ctl_in  = make_control(ls_ff, PID_SETUP);
            tok_in  = make_token(11'(SETUP_BYTES - PKT_W'(1)), 1'b0, 4'd0, addr_ff, PID_SETUP);
            obuf_in = sbuf_ff;
         end
         EMIT_DATA: begin
            ctl_in  = make_control(ls_ff, dpid);
            tok_in  = make_token(maxlen, tog_ff, 4'd0, addr_ff, dpid);
            obuf_in = buf_ff;
            tog_in  = !tog_ff;
            buf_in  = buf_ff + 32'(chunk);
            rem_in  = rem_ff - chunk;
         end
         EMIT_STATUS: begin
            ctl_in  = make_control(ls_ff, spid);
            tok_in  = make_token(LEN_MASK, 1'b1, 4'd0, addr_ff, spid);
            last_in = 1'b1;
         end
         EMIT_BULK: begin
            ctl_in  = make_control(ls_ff, dpid);
            tok_in  = make_token(maxlen, btog, ep_ff, addr_ff, dpid);
            obuf_in = buf_ff;
            last_in = stat.bulk_last;
            buf_in  = buf_ff + 32'(chunk);
            rem_in  = rem_ff - chunk;
            if (din_ff) tog_bin_in  = !tog_bin_ff;
            else        tog_bout_in = !tog_bout_ff;
         end
         EMIT_ERROR: begin
            last_in = 1'b1;
            err_in  = 1'b1;
         end
         EMIT_CHECK: begin
            last_in = fin_ff;
            rok_in  = c_ok;
            rto_in  = c_stop;
            rtot_in = c_total;
            if (fin_ff) begin
               ok_in    = 1'b1;
               stop_in  = 1'b0;
               total_in = '0;
            end else begin
               ok_in    = c_ok;
               stop_in  = c_stop;
               total_in = c_total;
            end
         end
         default: begin
            vld_in = vld_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= 1'b0;
         tog_bin_ff  <= 1'b0;
         tog_bout_ff <= 1'b0;
         ok_ff       <= 1'b1;
         stop_ff     <= 1'b0;
         total_ff    <= '0;
      end else begin
         vld_ff      <= vld_in;
         tog_bin_ff  <= tog_bin_in;
         tog_bout_ff <= tog_bout_in;
         ok_ff       <= ok_in;
         stop_ff     <= stop_in;
         total_ff    <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff   <= req_dev_address;
         ep_ff     <= req_endpoint;
         ls_ff     <= req_ls_dev;
         din_ff    <= req_dir_in;
         len_nz_ff <= (req_transfer_length != 16'd0);
         pkt_ff    <= (req_opcode == OP_BULK) ? BULK_PKT :
                      (req_mp0_bytes == 8'd0) ? DEFAULT_MP0 : PKT_W'(req_mp0_bytes);
         sbuf_ff   <= req_setup_address;
         st_ff     <= req_td_status;
         was_in_ff <= req_td_was_in;
         fin_ff    <= req_td_final;
      end
      rem_ff  <= rem_in;
      buf_ff  <= buf_in;
      cnt_ff  <= cnt_in;
      tog_ff  <= tog_in;
      ctl_ff  <= ctl_in;
      tok_ff  <= tok_in;
      obuf_ff <= obuf_in;
      last_ff <= last_in;
      err_ff  <= err_in;
      rok_ff  <= rok_in;
      rto_ff  <= rto_in;
      rtot_ff <= rtot_in;
   end

   assign rsp_valid         = vld_ff;
   assign rsp_td_control    = ctl_ff;
   assign rsp_td_token      = tok_ff;
   assign rsp_td_buffer     = obuf_ff;
   assign rsp_last          = last_ff;
   assign rsp_request_error = err_ff;
   assign rsp_transfer_ok   = rok_ff;
   assign rsp_timed_out     = rto_ff;
   assign rsp_actual_total  = rtot_ff;

   // a new result only goes into a free result slot
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emitting |-> stat.out_free)
      else $error("descriptor emitted into a busy result slot");

   // packet emissions always carry bytes
   a_data_rem: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit == EMIT_DATA || cmd.emit == EMIT_BULK) |-> (rem_ff != 16'd0))
      else $error("data packet with nothing left to send");

   // chain length bound
   a_chain_len: assert property (@(posedge clock) disable iff (reset)
      emitting |-> (cnt_ff < CNT_W'(MAX_DESCRIPTORS)))
      else $error("descriptor chain exceeds limit");

endmodule

FILE: hw/rtl/usb_td_chain_builder.sv
// ----------------------------------------------------------------------------
// usb_td_chain_builder
// Turns control/bulk requests into UHCI TD word sets; folds returned status.
// ----------------------------------------------------------------------------
//
//  channel   ports        direction  transfer
//  request   req_*        in         one control, bulk or check item
//  result    rsp_*        out        one TD word set, error mark or check sum
//
//  Flow: a request is taken while idle, then one TD per cycle while the result
//  side keeps up: control = setup + data TDs + a state change with no TD +
//  status, bulk = ceil(len/64) TDs (up to 40), check = 1 result. Throughput
//  is set by the single result register fed by the sequencer.
//  Reset clears the sequencer, result valid, bulk toggles and the check state.
//  A stalled result holds the sequencer; a new request is taken only when idle.
//
module usb_td_chain_builder
   import usbtd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [6:0]  req_dev_address,
   input  logic [3:0]  req_endpoint,
   input  logic        req_ls_dev,
   input  logic        req_dir_in,
   input  logic [15:0] req_transfer_length,
   input  logic [7:0]  req_mp0_bytes,
   input  logic [31:0] req_buffer_address,
   input  logic [31:0] req_setup_address,
   input  logic [31:0] req_td_status,
   input  logic        req_td_was_in,
   input  logic        req_td_final,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_td_control,
   output logic [31:0] rsp_td_token,
   output logic [31:0] rsp_td_buffer,
   output logic        rsp_last,
   output logic        rsp_request_error,
   output logic        rsp_transfer_ok,
   output logic        rsp_timed_out,
   output logic [16:0] rsp_actual_total
);

   cmd_type  cmd;   // load / emit kind from sequencer
   stat_type stat;  // slot free, remaining-bytes and chain-end flags

   usbtd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd)
   );

   usbtd_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_opcode          (req_opcode),
      .req_dev_address     (req_dev_address),
      .req_endpoint        (req_endpoint),
      .req_ls_dev          (req_ls_dev),
      .req_dir_in          (req_dir_in),
      .req_transfer_length (req_transfer_length),
      .req_mp0_bytes       (req_mp0_bytes),
      .req_buffer_address  (req_buffer_address),
      .req_setup_address   (req_setup_address),
      .req_td_status       (req_td_status),
      .req_td_was_in       (req_td_was_in),
      .req_td_final        (req_td_final),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_td_control      (rsp_td_control),
      .rsp_td_token        (rsp_td_token),
      .rsp_td_buffer       (rsp_td_buffer),
      .rsp_last            (rsp_last),
      .rsp_request_error   (rsp_request_error),
      .rsp_transfer_ok     (rsp_transfer_ok),
      .rsp_timed_out       (rsp_timed_out),
      .rsp_actual_total    (rsp_actual_total)
   );

endmodule

FILE: bench/tb_usb_td_chain_builder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_usb_td_chain_builder
// Self-checking bench for the UHCI TD chain builder.
// A queue-fed driver sends control, bulk and status-check transfers. A
// monitor predicts each TD word set and check sum, then compares every
// result field against the oldest prediction. It covers three pacing phases
// and both descriptor-count limits, check saturation and timeout.
// ----------------------------------------------------------------------------
module tb_usb_td_chain_builder
   import usbtd_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int END_PAUSE   = 40;

   // one request-side transfer, field per port
   typedef struct packed {
      opcode_type  opcode;
      logic [6:0]  dev_address;
      logic [3:0]  endpoint;
      logic        ls_dev;
      logic        dir_in;
      logic [15:0] transfer_length;
      logic [7:0]  mp0_bytes;
      logic [31:0] buffer_address;
      logic [31:0] setup_address;
      logic [31:0] td_status;
      logic        td_was_in;
      logic        td_final;
   } td_request_type;

   // one result-side transfer: TD word set or check sum
   typedef struct packed {
      logic [31:0] ctrl_word;
      logic [31:0] token_word;
      logic [31:0] buffer_word;
      logic        last;
      logic        request_error;
      logic        transfer_ok;
      logic        timed_out;
      logic [16:0] actual_total;
   } td_result_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   td_request_type req_bus = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   logic [31:0]    rsp_td_control;
   logic [31:0]    rsp_td_token;
   logic [31:0]    rsp_td_buffer;
   logic           rsp_last;
   logic           rsp_request_error;
   logic           rsp_transfer_ok;
   logic           rsp_timed_out;
   logic [16:0]    rsp_actual_total;

   logic [1:0]  req_opcode;
   logic [6:0]  req_dev_address;
   logic [3:0]  req_endpoint;
   logic        req_ls_dev;
   logic        req_dir_in;
   logic [15:0] req_transfer_length;
   logic [7:0]  req_mp0_bytes;
   logic [31:0] req_buffer_address;
   logic [31:0] req_setup_address;
   logic [31:0] req_td_status;
   logic        req_td_was_in;
   logic        req_td_final;

   td_request_type pending_requests[$];
   td_result_type  expected_results[$];

   // pacing, percent of cycles idle
   int send_idle_pct = 7;
   int recv_idle_pct = 76;

   // predictor state: bulk toggles per direction, running check fold
   logic        pred_tog_rx;
   logic        pred_tog_tx;
   logic        fold_ok;
   logic        fold_stopped;
   logic [16:0] fold_total;

   int error_count   = 0;
   int cycle_count   = 0;
   int n_control     = 0;
   int n_bulk        = 0;
   int n_check       = 0;
   int n_ignored     = 0;
   int n_compared    = 0;
   int n_truncated   = 0;
   int n_timeouts    = 0;
   int n_saturated   = 0;
   int longest_chain = 0;

   assign req_opcode          = req_bus.opcode;
   assign req_dev_address     = req_bus.dev_address;
   assign req_endpoint        = req_bus.endpoint;
   assign req_ls_dev          = req_bus.ls_dev;
   assign req_dir_in          = req_bus.dir_in;
   assign req_transfer_length = req_bus.transfer_length;
   assign req_mp0_bytes       = req_bus.mp0_bytes;
   assign req_buffer_address  = req_bus.buffer_address;
   assign req_setup_address   = req_bus.setup_address;
   assign req_td_status       = req_bus.td_status;
   assign req_td_was_in       = req_bus.td_was_in;
   assign req_td_final        = req_bus.td_final;

   usb_td_chain_builder u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_dev_address     (req_dev_address),
      .req_endpoint        (req_endpoint),
      .req_ls_dev          (req_ls_dev),
      .req_dir_in          (req_dir_in),
      .req_transfer_length (req_transfer_length),
      .req_mp0_bytes       (req_mp0_bytes),
      .req_buffer_address  (req_buffer_address),
      .req_setup_address   (req_setup_address),
      .req_td_status       (req_td_status),
      .req_td_was_in       (req_td_was_in),
      .req_td_final        (req_td_final),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_td_control      (rsp_td_control),
      .rsp_td_token        (rsp_td_token),
      .rsp_td_buffer       (rsp_td_buffer),
      .rsp_last            (rsp_last),
      .rsp_request_error   (rsp_request_error),
      .rsp_transfer_ok     (rsp_transfer_ok),
      .rsp_timed_out       (rsp_timed_out),
      .rsp_actual_total    (rsp_actual_total)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // one TD word set: control/status, token and buffer
   function automatic td_result_type td_words(input logic        ls,
                                              input logic [3:0]  ep,
                                              input logic [6:0]  dev,
                                              input logic [7:0]  pid,
                                              input logic        tog,
                                              input int unsigned nbytes,
                                              input logic [31:0] bufp,
                                              input logic        is_last);
      td_result_type w;
      logic [10:0]   maxlen;
      w = '0;
      // zero-length packets encode as all ones in the maxlen field
      maxlen = (nbytes == 0) ? LEN_MASK : 11'(nbytes - 1);
      w.ctrl_word = CS_ACTIVE | CS_ERRCNT;
      if (ls) w.ctrl_word = w.ctrl_word | CS_LS;
      if (pid == PID_IN) w.ctrl_word = w.ctrl_word | CS_SPD;
      w.token_word = (32'(maxlen) << 21) | (32'(tog) << 19) | (32'(ep) << 15)
                   | (32'(dev) << 8) | 32'(pid);
      w.buffer_word = bufp;
      w.last = is_last;
      return w;
   endfunction

   task automatic restart_fold();
      fold_ok      = 1'b1;
      fold_stopped = 1'b0;
      fold_total   = '0;
   endtask

   // works out every result that one accepted transfer causes
   task automatic predict_request(input td_request_type r);
      td_result_type w;
      int unsigned   mp;
      int unsigned   rem;
      int unsigned   chunk;
      int unsigned   sum;
      logic [31:0]   bufp;
      logic [7:0]    dpid;
      logic [10:0]   got;
      logic          tog;
      logic          is_last;
      int            n;
      n    = 0;
      rem  = r.transfer_length;
      bufp = r.buffer_address;
      dpid = r.dir_in ? PID_IN : PID_OUT;
      case (r.opcode)
         OP_CONTROL: begin
            n_control++;
            restart_fold();
            mp = (r.mp0_bytes == 8'd0) ? 8 : r.mp0_bytes;
            expected_results.push_back(td_words(r.ls_dev, 4'd0, r.dev_address,
               PID_SETUP, 1'b0, SETUP_BYTES, r.setup_address, 1'b0));
            n = 1;
            tog = 1'b1;
            // stop the data stage two descriptors short of the limit, room for the status stage
            while (rem > 0 && n < MAX_DESCRIPTORS - 2) begin
               chunk = (rem > mp) ? mp : rem;
               expected_results.push_back(td_words(r.ls_dev, 4'd0, r.dev_address,
                  dpid, tog, chunk, bufp, 1'b0));
               tog  = ~tog;
               bufp = bufp + chunk;
               rem  = rem - chunk;
               n++;
            end
            if (rem > 0) n_truncated++;
            // status stage runs opposite to the data stage, IN when no data
            expected_results.push_back(td_words(r.ls_dev, 4'd0, r.dev_address,
               (r.transfer_length != 0 && r.dir_in) ? PID_OUT : PID_IN,
               1'b1, 0, 32'd0, 1'b1));
            n++;
         end
         OP_BULK: begin
            n_bulk++;
            restart_fold();
            if (r.transfer_length == 16'd0) begin
               w = '0;
               w.last = 1'b1;
               w.request_error = 1'b1;
               expected_results.push_back(w);
               n = 1;
            end else begin
               while (rem > 0 && n < MAX_DESCRIPTORS) begin
                  chunk = (rem > BULK_PACKET_BYTES) ? BULK_PACKET_BYTES : rem;
                  tog = r.dir_in ? pred_tog_rx : pred_tog_tx;
                  rem = rem - chunk;
                  n++;
                  is_last = (rem == 0) || (n == MAX_DESCRIPTORS);
                  expected_results.push_back(td_words(r.ls_dev, r.endpoint,
                     r.dev_address, dpid, tog, chunk, bufp, is_last));
                  if (r.dir_in) pred_tog_rx = ~pred_tog_rx;
                  else pred_tog_tx = ~pred_tog_tx;
                  bufp = bufp + chunk;
               end
               if (rem > 0) n_truncated++;
            end
         end
         OP_CHECK: begin
            n_check++;
            if (!fold_stopped) begin
               if ((r.td_status & CS_ACTIVE) != 0) begin
                  // still active: timeout, counting ends for this chain
                  fold_ok = 1'b0;
                  fold_stopped = 1'b1;
                  n_timeouts++;
               end else begin
                  if ((r.td_status & CS_ERRBITS) != 0) fold_ok = 1'b0;
                  if (r.td_was_in) begin
                     // returned length is n-1; all ones counts as zero bytes
                     got = r.td_status[10:0] + 11'd1;
                     sum = fold_total + got;
                     if (sum > TOTAL_MAX) begin
                        sum = TOTAL_MAX;
                        n_saturated++;
                     end
                     fold_total = 17'(sum);
                  end
               end
            end
            w = '0;
            w.last = r.td_final;
            w.transfer_ok = fold_ok;
            w.timed_out = fold_stopped;
            w.actual_total = fold_total;
            expected_results.push_back(w);
            n = 1;
            if (r.td_final) restart_fold();
         end
         default: n_ignored++;
      endcase
      if (n > longest_chain) longest_chain = n;
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic flag_failure(input string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_result();
      td_result_type got;
      td_result_type want;
      got = {rsp_td_control, rsp_td_token, rsp_td_buffer, rsp_last,
             rsp_request_error, rsp_transfer_ok, rsp_timed_out, rsp_actual_total};
      if (expected_results.size() == 0) begin
         flag_failure($sformatf("result with nothing expected: %h", got));
      end else begin
         want = expected_results.pop_front();
         n_compared++;
         if (got.ctrl_word !== want.ctrl_word)
            flag_failure($sformatf("td_control got %h want %h",
                                   got.ctrl_word, want.ctrl_word));
         if (got.token_word !== want.token_word)
            flag_failure($sformatf("td_token got %h want %h",
                                   got.token_word, want.token_word));
         if (got.buffer_word !== want.buffer_word)
            flag_failure($sformatf("td_buffer got %h want %h",
                                   got.buffer_word, want.buffer_word));
         if (got.last !== want.last)
            flag_failure($sformatf("last got %b want %b", got.last, want.last));
         if (got.request_error !== want.request_error)
            flag_failure($sformatf("request_error got %b want %b",
                                   got.request_error, want.request_error));
         if (got.transfer_ok !== want.transfer_ok)
            flag_failure($sformatf("transfer_ok got %b want %b",
                                   got.transfer_ok, want.transfer_ok));
         if (got.timed_out !== want.timed_out)
            flag_failure($sformatf("timed_out got %b want %b",
                                   got.timed_out, want.timed_out));
         if (got.actual_total !== want.actual_total)
            flag_failure($sformatf("actual_total got %h want %h",
                                   got.actual_total, want.actual_total));
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver, receiver pacing and monitor
   // ------------------------------------------------------------------------

   // valid holds with a stable payload until the transfer is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_bus   <= '0;
      end else if (!req_valid || req_ready) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_bus   <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // results are checked before the new request is predicted: a result
   // taken on this edge always belongs to an earlier request
   always @(posedge clock) begin
      if (!reset) begin
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Test completed with failures");
            $finish;
         end else begin
            if (rsp_valid && rsp_ready) check_result();
            if (req_valid && req_ready) predict_request(req_bus);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   // every field random, so fields the opcode ignores still toggle
   function automatic td_request_type random_request(input opcode_type op);
      td_request_type r;
      r.opcode          = op;
      r.dev_address     = 7'($urandom);
      r.endpoint        = 4'($urandom);
      r.ls_dev          = 1'($urandom);
      r.dir_in          = 1'($urandom);
      r.transfer_length = 16'($urandom);
      r.mp0_bytes       = 8'($urandom);
      r.buffer_address  = $urandom;
      r.setup_address   = $urandom;
      r.td_status       = $urandom;
      r.td_was_in       = 1'($urandom);
      r.td_final        = 1'($urandom);
      return r;
   endfunction

   function automatic td_request_type check_word(input logic [31:0] status,
                                                 input logic was_in,
                                                 input logic is_last);
      td_request_type r;
      r = random_request(OP_CHECK);
      r.td_status = status;
      r.td_was_in = was_in;
      r.td_final  = is_last;
      return r;
   endfunction

   // mostly clean returned words, some active or with error bits
   function automatic logic [31:0] random_status();
      logic [31:0] st;
      int          pick;
      st = $urandom;
      if ($urandom_range(99) < 90) st = st & ~CS_ACTIVE;
      if ($urandom_range(99) < 80) st = st & ~CS_ERRBITS;
      pick = $urandom_range(9);
      if (pick == 0) st[10:0] = LEN_MASK;
      else if (pick == 1) st[10:0] = 11'd0;
      return st;
   endfunction

   task automatic queue_directed();
      td_request_type r;
      // control, no data stage, default packet size, both directions
      r = random_request(OP_CONTROL);
      r.transfer_length = 16'd0;
      r.mp0_bytes = 8'd0;
      r.dir_in = 1'b0;
      pending_requests.push_back(r);
      r.dir_in = 1'b1;
      r.ls_dev = 1'b0;
      pending_requests.push_back(r);
      // short IN data stage, status stage OUT
      r = random_request(OP_CONTROL);
      r.transfer_length = 16'd20;
      r.mp0_bytes = 8'd8;
      r.dir_in = 1'b1;
      pending_requests.push_back(r);
      // one-byte packets: data stage cut off by the descriptor limit
      r = random_request(OP_CONTROL);
      r.transfer_length = 16'hFFFF;
      r.mp0_bytes = 8'd1;
      r.dir_in = 1'b0;
      pending_requests.push_back(r);
      // largest packet size, low speed
      r = random_request(OP_CONTROL);
      r.transfer_length = 16'd300;
      r.mp0_bytes = 8'hFF;
      r.ls_dev = 1'b1;
      r.dir_in = 1'b1;
      pending_requests.push_back(r);
      // buffer address wraps around the top of memory
      r = random_request(OP_CONTROL);
      r.transfer_length = 16'd64;
      r.mp0_bytes = 8'd16;
      r.buffer_address = 32'hFFFF_FFF0;
      r.dev_address = 7'h7F;
      pending_requests.push_back(r);
      // zero-length bulk is an error, toggles untouched
      r = random_request(OP_BULK);
      r.transfer_length = 16'd0;
      pending_requests.push_back(r);
      r = random_request(OP_BULK);
      r.transfer_length = 16'd1;
      r.dir_in = 1'b1;
      r.endpoint = 4'hF;
      r.dev_address = 7'h7F;
      r.ls_dev = 1'b1;
      pending_requests.push_back(r);
      r = random_request(OP_BULK);
      r.transfer_length = 16'd64;
      r.dir_in = 1'b0;
      r.endpoint = 4'h0;
      r.dev_address = 7'h00;
      r.ls_dev = 1'b0;
      pending_requests.push_back(r);
      r = random_request(OP_BULK);
      r.transfer_length = 16'd65;
      r.dir_in = 1'b1;
      r.buffer_address = 32'hFFFF_FFE0;
      pending_requests.push_back(r);
      // exactly the descriptor limit, then well past it
      r = random_request(OP_BULK);
      r.transfer_length = 16'(MAX_DESCRIPTORS * BULK_PACKET_BYTES);
      r.dir_in = 1'b0;
      pending_requests.push_back(r);
      r = random_request(OP_BULK);
      r.transfer_length = 16'hFFFF;
      r.dir_in = 1'b1;
      pending_requests.push_back(r);
      // unused opcode: nothing comes back
      pending_requests.push_back(random_request(OP_UNUSED));
      // check chain: zero-byte code, one byte, error bits, timeout, then
      // words after the timeout that must change nothing
      pending_requests.push_back(check_word(32'h0000_07FF, 1'b1, 1'b0));
      pending_requests.push_back(check_word(32'h0000_0000, 1'b1, 1'b0));
      pending_requests.push_back(check_word(CS_ERRBITS | 32'h3F, 1'b0, 1'b0));
      pending_requests.push_back(check_word(CS_ACTIVE, 1'b1, 1'b0));
      pending_requests.push_back(check_word(32'h0000_0010, 1'b1, 1'b0));
      pending_requests.push_back(check_word(CS_ERRBITS, 1'b1, 1'b1));
      // a request in the middle of a chain restarts the fold
      pending_requests.push_back(check_word(32'h0000_0063, 1'b1, 1'b0));
      r = random_request(OP_BULK);
      r.transfer_length = 16'd10;
      pending_requests.push_back(r);
      pending_requests.push_back(check_word(32'h0000_0063, 1'b1, 1'b1));
      pending_requests.push_back(check_word(32'hFFFF_FFFF, 1'b1, 1'b1));
   endtask

   // long clean IN chain of full-size packets pushes the total to its cap
   task automatic queue_saturating_chain();
      logic [31:0] st;
      int          i;
      for (i = 0; i < 66; i++) begin
         st = $urandom & ~(CS_ACTIVE | CS_ERRBITS);
         st[10:0] = 11'h7FE;
         pending_requests.push_back(check_word(st, 1'b1, i == 65));
      end
   endtask

   task automatic queue_random(input int count);
      td_request_type r;
      int             added;
      int             kind;
      int             words;
      int             i;
      added = 0;
      while (added < count) begin
         kind = $urandom_range(99);
         if (kind < 5) begin
            pending_requests.push_back(random_request(OP_UNUSED));
         end else if (kind < 35) begin
            r = random_request(OP_CONTROL);
            kind = $urandom_range(99);
            if (kind < 60) r.transfer_length = 16'($urandom_range(64));
            else if (kind < 85) r.transfer_length = 16'($urandom_range(600));
            kind = $urandom_range(9);
            if (kind == 0) r.mp0_bytes = 8'd0;
            else if (kind == 1) r.mp0_bytes = 8'($urandom_range(1, 8));
            pending_requests.push_back(r);
            added++;
         end else if (kind < 65) begin
            r = random_request(OP_BULK);
            kind = $urandom_range(99);
            if (kind < 8) r.transfer_length = 16'd0;
            else if (kind < 58) r.transfer_length = 16'($urandom_range(1, 200));
            else if (kind < 83) r.transfer_length = 16'($urandom_range(1, 2600));
            pending_requests.push_back(r);
            added++;
         end else begin
            words = $urandom_range(1, 8);
            for (i = 0; i < words; i++)
               pending_requests.push_back(check_word(random_status(), 1'($urandom),
                  (i == words - 1) || ($urandom_range(99) < 5)));
            added += words;
         end
      end
   endtask

   // lets every queued transfer go in and every result come back
   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      pred_tog_rx = 1'b0;
      pred_tog_tx = 1'b0;
      restart_fold();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // phase 1: sender nearly always ready, receiver stalls a lot
      @(negedge clock);
      queue_directed();
      queue_random(45);
      wait_drained();

      // phase 2: sender gaps, receiver nearly always ready
      @(negedge clock);
      send_idle_pct = 76;
      recv_idle_pct = 7;
      queue_saturating_chain();
      queue_random(35);
      wait_drained();

      // phase 3: full rate on both sides
      @(negedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(55);
      wait_drained();

      repeat (END_PAUSE) @(posedge clock);
      if (expected_results.size() != 0)
         flag_failure($sformatf("%0d results never arrived", expected_results.size()));

      $display("Ran %0d control, %0d bulk, %0d check transfers, %0d ignored opcodes;",
               n_control, n_bulk, n_check, n_ignored);
      $display("%0d results compared, longest chain %0d, %0d cut at the limit,",
               n_compared, longest_chain, n_truncated);
      $display("%0d timeouts, %0d saturations.", n_timeouts, n_saturated);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
